[rtl/mvd_pkg.sv]
// mvd_pkg: shared constants and types for the minkowski vector distance core
// no dependencies

package mvd_pkg;

    localparam int ElemBits = 16;
    localparam int AccBits  = 64;
    localparam int DiffBits = ElemBits + 1;
    localparam int DistBits = 32;

    localparam logic [1:0] MODE_L1   = 2'd0;
    localparam logic [1:0] MODE_L2   = 2'd1;
    localparam logic [1:0] MODE_L5   = 2'd2;
    localparam logic [1:0] MODE_LINF = 2'd3;

    localparam logic [AccBits-1:0] ACC_MAX = {AccBits{1'b1}};

    // one classified request passed from front to back
    typedef struct packed {
        logic [DiffBits-1:0] ad;
        logic [1:0]          mode;
        logic                last;
    } mvd_job_t;

endpackage

[rtl/minkowski_vector_distance_core.sv]
// minkowski_vector_distance_core: top level, front classifier plus back engine
// depends on mvd_pkg, mvd_front, mvd_back
//
// channel  | handshake              | payload
// input    | in_valid / in_ready    | a_elem, b_elem, last_elem
// output   | out_valid / out_ready  | distance, overflowed
// config   | cfg_we                 | cfg_data (metric_mode)
//
// per pair: L1/Linf accumulate |a-b| directly, L2 and L5 first raise it to the power on the shared multiplier
// last pair adds a root: L2 32 steps, L5 13 steps, each on the shared multiplier
// a two-entry queue lets the front accept while the back works
// reset sets mode to L2 and clears the accumulator, its overflow flag and out_valid

module minkowski_vector_distance_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] a_elem,
    input  logic signed [15:0] b_elem,
    input  logic               last_elem,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        distance,
    output logic               overflowed,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_data
);
    import mvd_pkg::*;

    logic [1:0] mode_reg;
    logic       job_valid, job_ready;
    mvd_job_t   job;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_L2;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_data;
        end
    end

    mvd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a_elem    (a_elem),
        .b_elem    (b_elem),
        .last_elem (last_elem),
        .mode      (mode_reg),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    mvd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .distance   (distance),
        .overflowed (overflowed)
    );

endmodule

[rtl/mvd_front.sv]
// mvd_front: accepts element pairs, forms |a-b| and tags mode, two-entry queue
// depends on mvd_pkg

module mvd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [15:0]            a_elem,
    input  logic signed [15:0]            b_elem,
    input  logic                          last_elem,
    input  logic [1:0]                    mode,
    output logic                          job_valid,
    input  logic                          job_ready,
    output mvd_pkg::mvd_job_t             job
);
    import mvd_pkg::*;

    mvd_job_t            q_reg [2];
    logic                rd_ptr_reg, rd_ptr_next;
    logic                wr_ptr_reg, wr_ptr_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic signed [DiffBits-1:0] d;
    mvd_job_t            new_job;
    logic                push, pop;

    // absolute difference
    always_comb
    begin
        d = DiffBits'(a_elem) - DiffBits'(b_elem);
        new_job.ad   = d[DiffBits-1] ? DiffBits'(-d) : DiffBits'(d);
        new_job.mode = mode;
        new_job.last = last_elem;
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = job_valid && job_ready;

    // queue pointers
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_job;
        end
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !in_ready) else $error("queue overfill");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_empty_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> rd_ptr_reg == wr_ptr_reg) else $error("ptr mismatch");
`endif

endmodule

[rtl/mvd_back.sv]
// mvd_back: powers and accumulates (sum, or max for Linf), then square or fifth root for L2/L5
// depends on mvd_pkg

module mvd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  mvd_pkg::mvd_job_t     job,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           distance,
    output logic                  overflowed
);
    import mvd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_POW  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;
    localparam logic [2:0] ST_RCHK = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [AccBits-1:0]  acc_reg, acc_next;
    logic                ovf_reg, ovf_next;
    logic [AccBits-1:0]  p_reg, p_next;      // running power / root candidate power
    logic                pov_reg, pov_next;  // power saturated
    logic [2:0]          k_reg, k_next;      // multiplies left
    logic [DiffBits-1:0] x_reg, x_next;      // base of the power
    logic [1:0]          mode_reg, mode_next;
    logic                last_reg, last_next;
    logic [31:0]         r_reg, r_next;      // root result
    logic [4:0]          b_reg, b_next;      // root bit index
    logic [31:0]         dist_reg, dist_next;
    logic                oflag_reg, oflag_next;
    logic                ov_reg, ov_next;    // output register valid

    // shared multiplier: 64-bit product by a factor, split in halves
    // the high half only ever meets a factor of at most 17 bits
    // (|a-b| or a fifth-root candidate); a 32-bit square-root candidate
    // always comes with a zero high half
    logic [AccBits-1:0]  m_a;
    logic [31:0]         m_b;
    logic [63:0]         pp_lo;
    logic [48:0]         pp_hi;
    logic [95:0]         prod;
    logic                m_sat;
    logic [AccBits-1:0]  m_res;
    logic [31:0]         cand;
    logic [AccBits:0]    sum;

    assign pp_lo = m_a[31:0] * m_b;
    assign pp_hi = m_a[63:32] * m_b[16:0];
    assign prod  = {32'd0, pp_lo} + {15'd0, pp_hi, 32'd0};
    assign m_sat = (prod[95:64] != 32'd0);
    assign m_res = m_sat ? ACC_MAX : prod[63:0];
    assign cand  = r_reg | (32'd1 << b_reg);
    assign sum   = {1'b0, acc_reg} + {1'b0, p_reg};

    always_comb
    begin
        m_a = p_reg;
        m_b = 32'(x_reg);
        if (state_reg == ST_ROOT || state_reg == ST_RCHK)
        begin
            m_b = cand;
        end
    end

    assign job_ready  = (state_reg == ST_IDLE);
    assign out_valid  = ov_reg;
    assign distance   = dist_reg;
    assign overflowed = oflag_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        p_next     = p_reg;
        pov_next   = pov_reg;
        k_next     = k_reg;
        x_next     = x_reg;
        mode_next  = mode_reg;
        last_next  = last_reg;
        r_next     = r_reg;
        b_next     = b_reg;
        dist_next  = dist_reg;
        oflag_next = oflag_reg;
        ov_next    = ov_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    x_next    = job.ad;
                    p_next    = AccBits'(job.ad);
                    pov_next  = 1'b0;
                    mode_next = job.mode;
                    last_next = job.last;
                    case (job.mode)
                        MODE_L2: begin k_next = 3'd1; state_next = ST_POW; end
                        MODE_L5: begin k_next = 3'd4; state_next = ST_POW; end
                        default: state_next = ST_ACC;
                    endcase
                end
            end
            ST_POW:
            begin
                p_next   = m_res;
                pov_next = pov_reg | m_sat;
                k_next   = k_reg - 3'd1;
                if (k_reg == 3'd1)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (mode_reg == MODE_LINF)
                begin
                    if (p_reg > acc_reg)
                    begin
                        acc_next = p_reg;
                    end
                end
                else
                begin
                    acc_next = sum[AccBits] ? ACC_MAX : sum[AccBits-1:0];
                    ovf_next = ovf_reg | pov_reg | sum[AccBits];
                end
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (mode_reg == MODE_L2 || mode_reg == MODE_L5)
                begin
                    r_next     = 32'd0;
                    b_next     = (mode_reg == MODE_L2) ? 5'd31 : 5'd12;
                    state_next = ST_ROOT;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_ROOT:
            begin
                // load cand so that the first product in ST_RCHK is cand*cand
                p_next     = {32'd0, cand};
                pov_next   = 1'b0;
                k_next     = (mode_reg == MODE_L2) ? 3'd1 : 3'd4;
                state_next = ST_RCHK;
            end
            ST_RCHK:
            begin
                if (k_reg != 3'd0)
                begin
                    p_next   = m_res;
                    pov_next = pov_reg | m_sat;
                    k_next   = k_reg - 3'd1;
                end
                else
                begin
                    if (!pov_reg && p_reg <= acc_reg)
                    begin
                        r_next = cand;
                    end
                    if (b_reg == 5'd0)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        b_next     = b_reg - 5'd1;
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    if (mode_reg == MODE_L2 || mode_reg == MODE_L5)
                    begin
                        dist_next  = r_reg;
                        oflag_next = ovf_reg;
                    end
                    else
                    begin
                        dist_next  = (acc_reg[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                               : acc_reg[31:0];
                        oflag_next = ovf_reg | (acc_reg[63:32] != 32'd0);
                    end
                    ov_next    = 1'b1;
                    acc_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        pov_reg   <= pov_next;
        k_reg     <= k_next;
        x_reg     <= x_next;
        mode_reg  <= mode_next;
        last_reg  <= last_next;
        r_reg     <= r_next;
        b_reg     <= b_next;
        dist_reg  <= dist_next;
        oflag_reg <= oflag_next;
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_ready |=> $stable(dist_reg)) else $error("result changed");
    a_state: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg <= ST_OUT) else $error("bad state");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> acc_reg == '0) else $error("accumulator not cleared");
`endif

endmodule
